### hw/rtl/kced_pkg.sv
`default_nettype none
package kced_pkg;

	// counter and register widths
	localparam int TICK_W = 16;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 2;

	// event codes
	localparam logic [1:0] EV_NONE   = 2'd0;
	localparam logic [1:0] EV_SINGLE = 2'd1;
	localparam logic [1:0] EV_DOUBLE = 2'd2;
	localparam logic [1:0] EV_LONG   = 2'd3;

	// phase codes
	localparam logic [1:0] PH_RELEASED = 2'd0;
	localparam logic [1:0] PH_PRESSED  = 2'd1;
	localparam logic [1:0] PH_LONG     = 2'd2;

	// register indexes
	localparam logic [IDX_W-1:0] REG_SHORT_MIN  = 2'd0;
	localparam logic [IDX_W-1:0] REG_LONG_LIMIT = 2'd1;
	localparam logic [IDX_W-1:0] REG_CLICK_GAP  = 2'd2;

	typedef struct packed {
		logic [CFG_W-1:0] short_min_ticks;
		logic [CFG_W-1:0] long_limit_ticks;
		logic [CFG_W-1:0] click_gap_ticks;
	} cfg_t;

	// saturating tick counter increment
	function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
		logic [TICK_W-1:0] r;
		r = (v == {TICK_W{1'b1}}) ? v : v + {{(TICK_W-1){1'b0}}, 1'b1};
		return r;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/kced_if.sv
`default_nettype none
// key sample channel
interface kced_in_if;
	logic valid;
	logic ready;
	logic key_pressed;

	modport source (output valid, output key_pressed, input ready);
	modport sink (input valid, input key_pressed, output ready);
endinterface

// event result channel
interface kced_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_fired;
	logic [1:0] last_event;
	logic       key_level;
	logic [1:0] phase;

	modport source (output valid, output event_fired, output last_event,
		output key_level, output phase, input ready);
	modport sink (input valid, input event_fired, input last_event,
		input key_level, input phase, output ready);
endinterface
`default_nettype wire

### hw/rtl/kced_cfg.sv
`default_nettype none
module kced_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [kced_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [kced_pkg::CFG_W-1:0]     cfg_wdata,
	output kced_pkg::cfg_t                      cfg
);

	kced_pkg::cfg_t cfg_q;

	// register file; unknown index is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_min_ticks  <= kced_pkg::CFG_W'(2);
			cfg_q.long_limit_ticks <= kced_pkg::CFG_W'(100);
			cfg_q.click_gap_ticks  <= kced_pkg::CFG_W'(30);
		end else if (cfg_we) begin
			unique case (cfg_index)
				kced_pkg::REG_SHORT_MIN:  cfg_q.short_min_ticks  <= cfg_wdata;
				kced_pkg::REG_LONG_LIMIT: cfg_q.long_limit_ticks <= cfg_wdata;
				kced_pkg::REG_CLICK_GAP:  cfg_q.click_gap_ticks  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

### hw/rtl/key_click_event_detector.sv
`default_nettype none
// Key click event detector.
// One key sample per transfer enters on the sample channel (key_pressed).
// Each sample yields exactly one result on the result channel: the event of
// this tick (none, single, double, long press), the sticky last event, the
// sampled key level and the phase after the tick.
// Latency: the result is valid the cycle after the sample transfer.
// Throughput: one sample per cycle while the receiver is not stalling; the
// state update and the result register are loaded in the same cycle from the
// sample and the current state. When the receiver stalls, the result
// register holds and sample.ready drops until the result is taken; a sample
// is taken in the same cycle the pending result leaves.
// Configuration (short_min, long_limit, click_gap) is written through
// cfg_we/cfg_index/cfg_wdata; the user must write it only while the block is
// idle, which the block itself does not enforce; unknown indexes are ignored.
// Reset (arst_n low) clears the phase to released, both counters, the
// pending click, the last event and the result valid; registers return to
// short_min 2, long_limit 100, click_gap 30.
module key_click_event_detector (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [kced_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [kced_pkg::CFG_W-1:0]     cfg_wdata,
	kced_in_if.sink                             sample,
	kced_out_if.source                          result
);

	kced_pkg::cfg_t cfg;

	logic [1:0]                  phase_q;
	logic [kced_pkg::TICK_W-1:0] hold_q;
	logic [kced_pkg::TICK_W-1:0] gap_q;
	logic                        pending_q;
	logic [1:0]                  last_q;

	logic                        out_valid_q;
	logic [1:0]                  ev_q;
	logic                        level_q;

	logic                        take;
	logic [1:0]                  phase_d;
	logic [kced_pkg::TICK_W-1:0] hold_d;
	logic [kced_pkg::TICK_W-1:0] gap_d;
	logic                        pending_d;
	logic [1:0]                  ev_d;
	logic [kced_pkg::TICK_W-1:0] hold_inc;
	logic [kced_pkg::TICK_W-1:0] gap_inc;

	kced_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// accept while the result slot is empty or draining
	assign sample.ready = !out_valid_q || result.ready;
	assign take         = sample.valid && sample.ready;

	assign hold_inc = kced_pkg::sat_inc(hold_q);
	assign gap_inc  = kced_pkg::sat_inc(gap_q);

	// next-state and event logic
	always_comb begin
		phase_d   = phase_q;
		hold_d    = hold_q;
		gap_d     = gap_q;
		pending_d = pending_q;
		ev_d      = kced_pkg::EV_NONE;
		unique case (phase_q)
			kced_pkg::PH_PRESSED: begin
				if (sample.key_pressed) begin
					if (hold_inc > cfg.long_limit_ticks) begin
						hold_d  = '0;
						phase_d = kced_pkg::PH_LONG;
						ev_d    = kced_pkg::EV_LONG;
					end else begin
						hold_d = hold_inc;
					end
				end else begin
					phase_d = kced_pkg::PH_RELEASED;
					hold_d  = '0;
					// release inside the click window
					if (hold_q >= cfg.short_min_ticks && hold_q < cfg.long_limit_ticks) begin
						gap_d = '0;
						if (pending_q) begin
							pending_d = 1'b0;
							ev_d      = kced_pkg::EV_DOUBLE;
						end else begin
							pending_d = 1'b1;
						end
					end
				end
			end
			kced_pkg::PH_LONG: begin
				if (!sample.key_pressed)
					phase_d = kced_pkg::PH_RELEASED;
			end
			default: begin
				// released phase (and the unused code)
				if (sample.key_pressed) begin
					hold_d  = '0;
					phase_d = kced_pkg::PH_PRESSED;
				end else begin
					phase_d = kced_pkg::PH_RELEASED;
					if (pending_q) begin
						if (gap_inc > cfg.click_gap_ticks) begin
							gap_d     = '0;
							pending_d = 1'b0;
							ev_d      = kced_pkg::EV_SINGLE;
						end else begin
							gap_d = gap_inc;
						end
					end
				end
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= kced_pkg::PH_RELEASED;
			hold_q    <= '0;
			gap_q     <= '0;
			pending_q <= 1'b0;
			last_q    <= kced_pkg::EV_NONE;
		end else if (take) begin
			phase_q   <= phase_d;
			hold_q    <= hold_d;
			gap_q     <= gap_d;
			pending_q <= pending_d;
			if (ev_d != kced_pkg::EV_NONE)
				last_q <= ev_d;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (take) begin
			ev_q    <= ev_d;
			level_q <= sample.key_pressed;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.event_fired = ev_q;
	assign result.last_event  = last_q;
	assign result.key_level   = level_q;
	assign result.phase       = phase_q;

endmodule
`default_nettype wire
